@@ design/wspss_pkg.sv @@
`default_nettype none
package wspss_pkg;

  localparam int DATA_W    = 32;
  localparam int VAL_W     = 31;
  localparam int CNT_OUT_W = 7;
  localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = 7'd127;

  typedef struct packed {
    logic [DATA_W-1:0]        frame_number;
    logic signed [DATA_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] last_value;
    logic [CNT_OUT_W-1:0]     valid_count;
    logic [VAL_W-1:0]         mean_value;
    logic [VAL_W-1:0]         min_value;
    logic [VAL_W-1:0]         max_value;
  } out_t;

  typedef struct packed {
    logic clr;
    logic en;
  } acc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ design/wspss_ram.sv @@
`default_nettype none
module wspss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/wspss_div.sv @@
`default_nettype none
module wspss_div #(
  parameter int DVD_W = 38,
  parameter int DVS_W = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DVD_W-1:0]         dividend,
  input  logic [DVS_W-1:0]         divisor,
  output wspss_pkg::div_stat_t     stat,
  output logic [DVD_W-1:0]         quotient,
  output logic [DVS_W-1:0]         remainder
);
  import wspss_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  rq_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic              ge;
  logic [DVS_W:0]    diff;

  assign trial = {rem_r, rq_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rq_r   <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        step_r <= STEP_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        rq_r   <= {rq_r[DVD_W-2:0], ge};
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat      = '{busy: busy_r, done: done_r};
  assign quotient  = rq_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

@@ design/wspss_acc.sv @@
`default_nettype none
module wspss_acc #(
  parameter int CNT_W = 7,
  parameter int SUM_W = 38
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wspss_pkg::acc_ctl_t           ctl,
  input  logic [wspss_pkg::DATA_W-1:0]  data,
  output logic [CNT_W-1:0]              count,
  output logic [SUM_W-1:0]              sum,
  output logic [wspss_pkg::VAL_W-1:0]   lo,
  output logic [wspss_pkg::VAL_W-1:0]   hi
);
  import wspss_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sum_r;
  logic [VAL_W-1:0] lo_r;
  logic [VAL_W-1:0] hi_r;
  logic             pos;
  logic [VAL_W-1:0] val;

  assign pos = !data[DATA_W-1] && (data != '0);
  assign val = data[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      count_r <= '0;
      sum_r   <= '0;
      lo_r    <= '1;
      hi_r    <= '0;
    end else if (ctl.en && pos) begin
      count_r <= count_r + CNT_W'(1);
      sum_r   <= sum_r + SUM_W'(val);
      if (val < lo_r) begin
        lo_r <= val;
      end
      if (val > hi_r) begin
        hi_r <= val;
      end
    end
  end

  assign count = count_r;
  assign sum   = sum_r;
  assign lo    = lo_r;
  assign hi    = hi_r;

endmodule
`default_nettype wire

@@ design/windowed_positive_sample_stats_unit.sv @@
`default_nettype none
// Keeps a ring of HISTORY_DEPTH timing samples (signed Q16.16), cleared at reset, and for
// every request writes the sample into slot frame_number mod HISTORY_DEPTH, rescans the
// ring and returns the sample, the count of positive entries and their min, max and
// truncated mean (all zero when none is positive). After reset the ring is zeroed one slot
// a cycle with in_ready low. A request then reads the ring one entry a cycle through the
// single-port ring memory, then divides the sum by the count one quotient bit a cycle in
// the shared shift-subtract divider; the divide is skipped when no entry is positive. A
// depth that is not a power of two first uses the divider to reduce the frame number to a
// slot. in_ready is high only between requests; a finished result waits in the output
// register while the next request is taken.
module windowed_positive_sample_stats_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wspss_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wspss_pkg::out_t   out_data
);
  import wspss_pkg::*;

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = VAL_W + CNT_W;
  localparam int CW      = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam bit IS_POW2 = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_DIVST = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [DATA_W-1:0] last_r, last_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [VAL_W-1:0]  mean_r, mean_nxt;
  out_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic              div_start;
  logic [SUM_W-1:0]  div_dvd;
  logic [CNT_W-1:0]  div_dvs;
  div_stat_t         div_stat;
  logic [SUM_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_rem;

  acc_ctl_t          acc_ctl;
  logic [CNT_W-1:0]  acc_cnt;
  logic [SUM_W-1:0]  acc_sum;
  logic [VAL_W-1:0]  acc_lo;
  logic [VAL_W-1:0]  acc_hi;
  logic [CW-1:0]     cnt_ext;
  logic              none_pos;

  wspss_ram #(.WIDTH(DATA_W), .DEPTH(HISTORY_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  wspss_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  wspss_acc #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .data  (ram_rdata),
    .count (acc_cnt),
    .sum   (acc_sum),
    .lo    (acc_lo),
    .hi    (acc_hi)
  );

  assign cnt_ext  = CW'(acc_cnt);
  assign none_pos = (acc_cnt == '0);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    slot_nxt      = slot_r;
    last_nxt      = last_r;
    rd_vld_nxt    = 1'b0;
    mean_nxt      = mean_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_addr      = ptr_r;
    ram_wdata     = '0;
    div_start     = 1'b0;
    div_dvd       = acc_sum;
    div_dvs       = acc_cnt;
    acc_ctl       = '{clr: 1'b0, en: rd_vld_r};
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_r == LAST_SLOT) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_data.sample_value;
          if (IS_POW2) begin
            slot_nxt  = in_data.frame_number[AW-1:0];
            state_nxt = S_WRITE;
          end else begin
            div_start = 1'b1;
            div_dvd   = SUM_W'(in_data.frame_number);
            div_dvs   = CNT_W'(HISTORY_DEPTH);
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          slot_nxt  = div_rem[AW-1:0];
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        ram_addr    = slot_r;
        ram_wdata   = last_r;
        acc_ctl.clr = 1'b1;
        ptr_nxt     = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (ptr_r == LAST_SLOT) begin
          ptr_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIVST;
      end
      S_DIVST: begin
        if (none_pos) begin
          mean_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mean_nxt  = div_quo[VAL_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.last_value  = last_r;
          out_nxt.valid_count = (cnt_ext > CW'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                             : cnt_ext[CNT_OUT_W-1:0];
          out_nxt.mean_value  = mean_r;
          out_nxt.min_value   = none_pos ? '0 : acc_lo;
          out_nxt.max_value   = none_pos ? '0 : acc_hi;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    last_r <= last_nxt;
    mean_r <= mean_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("ready high right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while one is in progress");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_cnt <= CNT_W'(HISTORY_DEPTH))
    else $error("positive count beyond ring depth");

  a_mean_between: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.valid_count != '0) |->
      (out_data.min_value <= out_data.mean_value &&
       out_data.mean_value <= out_data.max_value))
    else $error("mean outside min and max");

endmodule
`default_nettype wire
